// ===== rtl/lcdns_pkg.sv =====
// Shared types, command codes and timing constants for the LCD nibble sequencer.
`default_nettype none
package lcdns_pkg;

  localparam int unsigned OpcodeW = 5;
  localparam int unsigned ColW    = 6;
  localparam int unsigned RowW    = 2;
  localparam int unsigned DataW   = 8;
  localparam int unsigned NibW    = 4;
  localparam int unsigned LeadW   = 16;
  localparam int unsigned SettleW = 13;
  localparam int unsigned LinesW  = 3;
  localparam int unsigned StepW   = 4;

  localparam int unsigned InTdataW  = 24;
  localparam int unsigned OutTdataW = 40;

  localparam int unsigned MaxRowsDefault = 4;

  localparam logic [LeadW-1:0]   LeadPowerUp  = 16'd50000;
  localparam logic [SettleW-1:0] SettleWake   = 13'd4500;
  localparam logic [SettleW-1:0] SettleSlow   = 13'd2000;
  localparam logic [SettleW-1:0] SettleNormal = 13'd100;

  localparam logic [StepW-1:0] InitLastStep = 4'd13;

  // Configuration register indexes
  localparam logic [1:0] CfgNumLines = 2'd0;
  localparam logic [1:0] CfgTallFont = 2'd1;

  typedef enum logic [OpcodeW-1:0] {
    OP_INIT        = 5'd0,
    OP_CLEAR       = 5'd1,
    OP_HOME        = 5'd2,
    OP_SET_CURSOR  = 5'd3,
    OP_DISP_ON     = 5'd4,
    OP_DISP_OFF    = 5'd5,
    OP_CURSOR_ON   = 5'd6,
    OP_CURSOR_OFF  = 5'd7,
    OP_BLINK_ON    = 5'd8,
    OP_BLINK_OFF   = 5'd9,
    OP_SCROLL_L    = 5'd10,
    OP_SCROLL_R    = 5'd11,
    OP_LEFT_RIGHT  = 5'd12,
    OP_RIGHT_LEFT  = 5'd13,
    OP_AUTOSCR_ON  = 5'd14,
    OP_AUTOSCR_OFF = 5'd15,
    OP_GLYPH_LOC   = 5'd16,
    OP_WRITE_DATA  = 5'd17
  } opcode_t;

  // One queued job: either the init run (byte holds function set) or one byte.
  typedef struct packed {
    logic             is_init;
    logic             rs;
    logic             slow;
    logic [DataW-1:0] byte_val;
  } job_t;

  function automatic logic [6:0] row_base(input logic [RowW-1:0] row);
    logic [6:0] base;
    case (row)
      2'd0:    base = 7'h00;
      2'd1:    base = 7'h40;
      2'd2:    base = 7'h14;
      default: base = 7'h54;
    endcase
    return base;
  endfunction

  // Nibble for each step of the init run.
  function automatic logic [NibW-1:0] init_nibble(input logic [StepW-1:0] step,
                                                   input logic [DataW-1:0] func);
    logic [NibW-1:0] nib;
    case (step)
      4'd0, 4'd1, 4'd2: nib = 4'h3;
      4'd3:             nib = 4'h2;
      4'd4:             nib = func[7:4];
      4'd5:             nib = func[3:0];
      4'd6:             nib = 4'h0;
      4'd7:             nib = 4'h8;
      4'd8:             nib = 4'h0;
      4'd9:             nib = 4'h1;
      4'd10:            nib = 4'h0;
      4'd11:            nib = 4'h6;
      4'd12:            nib = 4'h0;
      4'd13:            nib = 4'hC;
      default:          nib = 4'h0;
    endcase
    return nib;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/char_lcd_nibble_command_sequencer_core.sv =====
// Top level of the character-LCD 4-bit command sequencer.
//
//  channel | direction | transfer when          | carries
//  --------+-----------+------------------------+--------------------------------
//  in_     | in        | in_tvalid & in_tready  | one display operation
//  out_    | out       | out_tvalid & out_tready| one 4-bit bus transfer
//  cfg_    | in        | cfg_valid & cfg_ready  | register index and value
//
// Each operation yields two transfers (init yields fourteen), one per cycle from the
// output register while out_tready is high, so the bus sequencer sets the output pace.
// The front end takes operations while the four-entry job queue has room, so input
// keeps flowing while out_tready is low until the queue fills.
// Unknown opcodes are taken and dropped. Reset is synchronous; cfg_ready is always high.
`default_nettype none
module char_lcd_nibble_command_sequencer_core #(
  parameter int unsigned MAX_ROWS = lcdns_pkg::MaxRowsDefault
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // [4:0] opcode, [10:5] col, [12:11] row, [20:13] data_value, [23:21] zero
  input  wire logic [lcdns_pkg::InTdataW-1:0]      in_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [3:0] nibble, [19:4] lead_wait_us, [32:20] settle_wait_us, [39:33] zero
  output logic [lcdns_pkg::OutTdataW-1:0]          out_tdata,
  // [0] reg_select
  output logic                                     out_tuser,
  output logic                                     out_tlast,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [1:0]                          cfg_index,
  input  wire logic [lcdns_pkg::LinesW-1:0]        cfg_data
);
  import lcdns_pkg::*;

  logic               q_push, q_full, q_ne, q_pop;
  job_t               push_job, head_job;
  logic [NibW-1:0]    nib;
  logic [LeadW-1:0]   lead;
  logic [SettleW-1:0] settle;

  assign cfg_ready = 1'b1;

  lcdns_front #(.MAX_ROWS(MAX_ROWS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .op_valid  (in_tvalid),
    .op_code   (in_tdata[4:0]),
    .op_col    (in_tdata[10:5]),
    .op_row    (in_tdata[12:11]),
    .op_data   (in_tdata[20:13]),
    .q_full    (q_full),
    .op_ready  (in_tready),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  lcdns_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (push_job),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_ne),
    .head_job  (head_job)
  );

  lcdns_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (q_ne),
    .job        (head_job),
    .job_pop    (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_rs     (out_tuser),
    .out_nib    (nib),
    .out_lead   (lead),
    .out_settle (settle),
    .out_last   (out_tlast)
  );

  assign out_tdata = {7'd0, settle, lead, nib};

endmodule
`default_nettype wire

// ===== rtl/lcdns_front.sv =====
// Front end: takes operations, tracks mode bits and config, builds queued jobs.
`default_nettype none
module lcdns_front #(
  parameter int unsigned MAX_ROWS = lcdns_pkg::MaxRowsDefault
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_valid,
  input  wire logic [1:0]                      cfg_index,
  input  wire logic [lcdns_pkg::LinesW-1:0]    cfg_data,
  input  wire logic                            op_valid,
  input  wire logic [lcdns_pkg::OpcodeW-1:0]   op_code,
  input  wire logic [lcdns_pkg::ColW-1:0]      op_col,
  input  wire logic [lcdns_pkg::RowW-1:0]      op_row,
  input  wire logic [lcdns_pkg::DataW-1:0]     op_data,
  input  wire logic                            q_full,
  output logic                                 op_ready,
  output logic                                 q_push,
  output lcdns_pkg::job_t                      q_job
);
  import lcdns_pkg::*;

  localparam logic [LinesW-1:0] MaxLines = LinesW'(MAX_ROWS);

  logic [LinesW-1:0] num_lines_r;
  logic              tall_font_r;
  logic [2:0]        disp_r, disp_nxt;
  logic [1:0]        entry_r, entry_nxt;

  logic              take;
  logic              known;
  logic [LinesW-1:0] lines, lines_cap;
  logic [RowW-1:0]   row_cl;
  logic [6:0]        addr;
  logic [DataW-1:0]  func;

  assign op_ready = !q_full;
  assign take     = op_valid && op_ready;
  assign q_push   = take && known;

  always_comb begin
    lines     = (num_lines_r == '0) ? LinesW'(1) : num_lines_r;
    lines_cap = (lines > MaxLines) ? MaxLines : lines;
    if ({1'b0, op_row} >= lines_cap) begin
      row_cl = RowW'(lines_cap - LinesW'(1));
    end else begin
      row_cl = op_row;
    end
    addr = 7'(op_col) + row_base(row_cl);
    func = 8'h20;
    if (lines > LinesW'(1)) func[3] = 1'b1;
    if (tall_font_r && lines == LinesW'(1)) func[2] = 1'b1;
  end

  always_comb begin
    disp_nxt         = disp_r;
    entry_nxt        = entry_r;
    known            = 1'b1;
    q_job.is_init    = 1'b0;
    q_job.rs         = 1'b0;
    q_job.slow       = 1'b0;
    q_job.byte_val   = '0;
    case (op_code)
      OP_INIT: begin
        q_job.is_init  = 1'b1;
        q_job.byte_val = func;
        disp_nxt       = 3'b100;
        entry_nxt      = 2'b10;
      end
      OP_CLEAR: begin
        q_job.slow     = 1'b1;
        q_job.byte_val = 8'h01;
      end
      OP_HOME: begin
        q_job.slow     = 1'b1;
        q_job.byte_val = 8'h02;
      end
      OP_SET_CURSOR: q_job.byte_val = {1'b1, addr};
      OP_DISP_ON, OP_DISP_OFF, OP_CURSOR_ON, OP_CURSOR_OFF,
      OP_BLINK_ON, OP_BLINK_OFF: begin
        case (op_code)
          OP_DISP_ON:    disp_nxt[2] = 1'b1;
          OP_DISP_OFF:   disp_nxt[2] = 1'b0;
          OP_CURSOR_ON:  disp_nxt[1] = 1'b1;
          OP_CURSOR_OFF: disp_nxt[1] = 1'b0;
          OP_BLINK_ON:   disp_nxt[0] = 1'b1;
          default:       disp_nxt[0] = 1'b0;
        endcase
        q_job.byte_val = {5'b00001, disp_nxt};
      end
      OP_SCROLL_L: q_job.byte_val = 8'h18;
      OP_SCROLL_R: q_job.byte_val = 8'h1C;
      OP_LEFT_RIGHT, OP_RIGHT_LEFT, OP_AUTOSCR_ON, OP_AUTOSCR_OFF: begin
        case (op_code)
          OP_LEFT_RIGHT: entry_nxt[1] = 1'b1;
          OP_RIGHT_LEFT: entry_nxt[1] = 1'b0;
          OP_AUTOSCR_ON: entry_nxt[0] = 1'b1;
          default:       entry_nxt[0] = 1'b0;
        endcase
        q_job.byte_val = {6'b000001, entry_nxt};
      end
      OP_GLYPH_LOC:  q_job.byte_val = {2'b01, op_data[2:0], 3'b000};
      OP_WRITE_DATA: begin
        q_job.rs       = 1'b1;
        q_job.byte_val = op_data;
      end
      default: known = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_lines_r <= LinesW'(2);
      tall_font_r <= 1'b0;
      disp_r      <= '0;
      entry_r     <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CfgNumLines: num_lines_r <= cfg_data;
          CfgTallFont: tall_font_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (q_push) begin
        disp_r  <= disp_nxt;
        entry_r <= entry_nxt;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lcdns_fifo.sv =====
// Short job queue between front end and bus sequencer.
`default_nettype none
module lcdns_fifo (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire lcdns_pkg::job_t  push_job,
  input  wire logic             pop,
  output logic                  full,
  output logic                  not_empty,
  output lcdns_pkg::job_t       head_job
);
  import lcdns_pkg::*;

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);

  job_t            mem_r [Depth];
  logic [PtrW-1:0] wptr_r, rptr_r;
  logic [PtrW:0]   count_r;

  assign full      = (count_r == (PtrW+1)'(Depth));
  assign not_empty = (count_r != '0);
  assign head_job  = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + PtrW'(1);
      if (pop)  rptr_r <= rptr_r + PtrW'(1);
      case ({push, pop})
        2'b10:   count_r <= count_r + (PtrW+1)'(1);
        2'b01:   count_r <= count_r - (PtrW+1)'(1);
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lcdns_back.sv =====
// Back end: expands each job into nibble transfers into an output register.
`default_nettype none
module lcdns_back (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           job_valid,
  input  wire lcdns_pkg::job_t                job,
  output logic                                job_pop,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_rs,
  output logic [lcdns_pkg::NibW-1:0]          out_nib,
  output logic [lcdns_pkg::LeadW-1:0]         out_lead,
  output logic [lcdns_pkg::SettleW-1:0]       out_settle,
  output logic                                out_last
);
  import lcdns_pkg::*;

  logic               valid_r;
  logic [StepW-1:0]   step_r;
  logic               rs_r, last_r;
  logic [NibW-1:0]    nib_r;
  logic [LeadW-1:0]   lead_r;
  logic [SettleW-1:0] settle_r;

  logic               load;
  logic               fin;
  logic [NibW-1:0]    nib_c;
  logic [LeadW-1:0]   lead_c;
  logic [SettleW-1:0] settle_c;

  assign load    = job_valid && (!valid_r || out_ready);
  assign job_pop = load && fin;

  always_comb begin
    lead_c   = '0;
    settle_c = SettleNormal;
    if (job.is_init) begin
      fin   = (step_r == InitLastStep);
      nib_c = init_nibble(step_r, job.byte_val);
      if (step_r == '0) begin
        lead_c   = LeadPowerUp;
        settle_c = SettleWake;
      end else if (step_r == StepW'(9)) begin
        settle_c = SettleSlow;
      end
    end else begin
      fin   = step_r[0];
      nib_c = step_r[0] ? job.byte_val[3:0] : job.byte_val[7:4];
      if (step_r[0] && job.slow) settle_c = SettleSlow;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      step_r  <= '0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        step_r  <= fin ? '0 : step_r + StepW'(1);
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rs_r     <= job.rs;
      nib_r    <= nib_c;
      lead_r   <= lead_c;
      settle_r <= settle_c;
      last_r   <= fin;
    end
  end

  assign out_valid  = valid_r;
  assign out_rs     = rs_r;
  assign out_nib    = nib_r;
  assign out_lead   = lead_r;
  assign out_settle = settle_r;
  assign out_last   = last_r;

endmodule
`default_nettype wire
